// ===== hw/rtl/kscd_pkg.sv =====
// shared types, prefix codes and translation tables of the scan-code decoder
`timescale 1ns / 1ps

package kscd_pkg;

	// prefix state
	typedef logic [1:0] pstate_t;
	localparam pstate_t PS_NORMAL    = 2'd0;
	localparam pstate_t PS_AFTER_E0  = 2'd1;
	localparam pstate_t PS_E1_FIRST  = 2'd2;
	localparam pstate_t PS_E1_SECOND = 2'd3;

	// prefix bytes
	localparam logic [7:0] PREFIX_E0 = 8'hE0;
	localparam logic [7:0] PREFIX_E1 = 8'hE1;

	// table entry: zero means none, bit 7 set means special index in bits 6..0
	typedef logic [7:0] entry_t;

	// translated item handed from the lookup to the result register
	typedef struct packed {
		logic       hit;
		logic [6:0] key_code;
		logic       is_special;
		logic       released;
	} kscd_res_t;

	// special key indices
	localparam logic [6:0] K_LCTRL    = 7'd0;
	localparam logic [6:0] K_RCTRL    = 7'd1;
	localparam logic [6:0] K_LSHIFT   = 7'd2;
	localparam logic [6:0] K_RSHIFT   = 7'd3;
	localparam logic [6:0] K_LALT     = 7'd4;
	localparam logic [6:0] K_RALT     = 7'd5;
	localparam logic [6:0] K_CAPS     = 7'd6;
	localparam logic [6:0] K_NUMLK    = 7'd7;
	localparam logic [6:0] K_SCRLK    = 7'd8;
	localparam logic [6:0] K_F1       = 7'd9;
	localparam logic [6:0] K_F2       = 7'd10;
	localparam logic [6:0] K_F3       = 7'd11;
	localparam logic [6:0] K_F4       = 7'd12;
	localparam logic [6:0] K_F5       = 7'd13;
	localparam logic [6:0] K_F6       = 7'd14;
	localparam logic [6:0] K_F7       = 7'd15;
	localparam logic [6:0] K_F8       = 7'd16;
	localparam logic [6:0] K_F9       = 7'd17;
	localparam logic [6:0] K_F10      = 7'd18;
	localparam logic [6:0] K_F11      = 7'd19;
	localparam logic [6:0] K_F12      = 7'd20;
	localparam logic [6:0] K_KP0      = 7'd21;
	localparam logic [6:0] K_KP1      = 7'd22;
	localparam logic [6:0] K_KP2      = 7'd23;
	localparam logic [6:0] K_KP3      = 7'd24;
	localparam logic [6:0] K_KP4      = 7'd25;
	localparam logic [6:0] K_KP5      = 7'd26;
	localparam logic [6:0] K_KP6      = 7'd27;
	localparam logic [6:0] K_KP7      = 7'd28;
	localparam logic [6:0] K_KP8      = 7'd29;
	localparam logic [6:0] K_KP9      = 7'd30;
	localparam logic [6:0] K_KPMINUS  = 7'd31;
	localparam logic [6:0] K_KPPLUS   = 7'd32;
	localparam logic [6:0] K_KPSTAR   = 7'd33;
	localparam logic [6:0] K_KPSLASH  = 7'd34;
	localparam logic [6:0] K_KPDOT    = 7'd35;
	localparam logic [6:0] K_KPENTER  = 7'd36;
	localparam logic [6:0] K_HOME     = 7'd37;
	localparam logic [6:0] K_END      = 7'd38;
	localparam logic [6:0] K_PGUP     = 7'd39;
	localparam logic [6:0] K_PGDN     = 7'd40;
	localparam logic [6:0] K_INS      = 7'd41;
	localparam logic [6:0] K_DEL      = 7'd42;
	localparam logic [6:0] K_UP       = 7'd43;
	localparam logic [6:0] K_DOWN     = 7'd44;
	localparam logic [6:0] K_LEFT     = 7'd45;
	localparam logic [6:0] K_RIGHT    = 7'd46;
	localparam logic [6:0] K_LGUI     = 7'd47;
	localparam logic [6:0] K_RGUI     = 7'd48;
	localparam logic [6:0] K_MENU     = 7'd49;
	localparam logic [6:0] K_PRNSCR   = 7'd50;
	localparam logic [6:0] K_PAUSE    = 7'd51;
	localparam logic [6:0] K_SYSRQ    = 7'd52;

	// entry builders
	function automatic entry_t sp(input logic [6:0] k);
		return {1'b1, k};
	endfunction

	function automatic entry_t asc(input logic [7:0] c);
		return {1'b0, c[6:0]};
	endfunction

	// base table, indices 0 to 88, anything beyond reads as empty
	function automatic entry_t base_entry(input logic [6:0] idx);
		entry_t e;
		e = '0;
		case (idx)
			7'd1:  e = asc(8'd27);
			7'd2:  e = asc("1");
			7'd3:  e = asc("2");
			7'd4:  e = asc("3");
			7'd5:  e = asc("4");
			7'd6:  e = asc("5");
			7'd7:  e = asc("6");
			7'd8:  e = asc("7");
			7'd9:  e = asc("8");
			7'd10: e = asc("9");
			7'd11: e = asc("0");
			7'd12: e = asc("-");
			7'd13: e = asc("=");
			7'd14: e = asc(8'd8);
			7'd15: e = asc(8'd9);
			7'd16: e = asc("Q");
			7'd17: e = asc("W");
			7'd18: e = asc("E");
			7'd19: e = asc("R");
			7'd20: e = asc("T");
			7'd21: e = asc("Y");
			7'd22: e = asc("U");
			7'd23: e = asc("I");
			7'd24: e = asc("O");
			7'd25: e = asc("P");
			7'd26: e = asc("[");
			7'd27: e = asc("]");
			7'd28: e = asc(8'd10);
			7'd29: e = sp(K_LCTRL);
			7'd30: e = asc("A");
			7'd31: e = asc("S");
			7'd32: e = asc("D");
			7'd33: e = asc("F");
			7'd34: e = asc("G");
			7'd35: e = asc("H");
			7'd36: e = asc("J");
			7'd37: e = asc("K");
			7'd38: e = asc("L");
			7'd39: e = asc(";");
			7'd40: e = asc(8'h27);
			7'd41: e = asc(8'h60);
			7'd42: e = sp(K_LSHIFT);
			7'd43: e = asc(8'h5C);
			7'd44: e = asc("Z");
			7'd45: e = asc("X");
			7'd46: e = asc("C");
			7'd47: e = asc("V");
			7'd48: e = asc("B");
			7'd49: e = asc("N");
			7'd50: e = asc("M");
			7'd51: e = asc(",");
			7'd52: e = asc(".");
			7'd53: e = asc("/");
			7'd54: e = sp(K_RSHIFT);
			7'd55: e = sp(K_KPSTAR);
			7'd56: e = sp(K_LALT);
			7'd57: e = asc(" ");
			7'd58: e = sp(K_CAPS);
			7'd59: e = sp(K_F1);
			7'd60: e = sp(K_F2);
			7'd61: e = sp(K_F3);
			7'd62: e = sp(K_F4);
			7'd63: e = sp(K_F5);
			7'd64: e = sp(K_F6);
			7'd65: e = sp(K_F7);
			7'd66: e = sp(K_F8);
			7'd67: e = sp(K_F9);
			7'd68: e = sp(K_F10);
			7'd69: e = sp(K_NUMLK);
			7'd70: e = sp(K_SCRLK);
			7'd71: e = sp(K_KP7);
			7'd72: e = sp(K_KP8);
			7'd73: e = sp(K_KP9);
			7'd74: e = sp(K_KPMINUS);
			7'd75: e = sp(K_KP4);
			7'd76: e = sp(K_KP5);
			7'd77: e = sp(K_KP6);
			7'd78: e = sp(K_KPPLUS);
			7'd79: e = sp(K_KP1);
			7'd80: e = sp(K_KP2);
			7'd81: e = sp(K_KP3);
			7'd82: e = sp(K_KP0);
			7'd83: e = sp(K_KPDOT);
			7'd84: e = sp(K_SYSRQ);
			7'd86: e = asc(8'h5C);
			7'd87: e = sp(K_F11);
			7'd88: e = sp(K_F12);
			default: e = '0;
		endcase
		return e;
	endfunction

	// extended table for the byte after E0
	function automatic entry_t ext_entry(input logic [6:0] idx);
		entry_t e;
		e = '0;
		case (idx)
			7'h1C: e = sp(K_KPENTER);
			7'h1D: e = sp(K_RCTRL);
			7'h35: e = sp(K_KPSLASH);
			7'h37: e = sp(K_PRNSCR);
			7'h38: e = sp(K_RALT);
			7'h45: e = sp(K_NUMLK);
			7'h47: e = sp(K_HOME);
			7'h48: e = sp(K_UP);
			7'h49: e = sp(K_PGUP);
			7'h4B: e = sp(K_LEFT);
			7'h4D: e = sp(K_RIGHT);
			7'h4F: e = sp(K_END);
			7'h50: e = sp(K_DOWN);
			7'h51: e = sp(K_PGDN);
			7'h52: e = sp(K_INS);
			7'h53: e = sp(K_DEL);
			7'h5B: e = sp(K_LGUI);
			7'h5C: e = sp(K_RGUI);
			7'h5D: e = sp(K_MENU);
			default: e = '0;
		endcase
		return e;
	endfunction

endpackage

// ===== hw/rtl/kscd_lookup.sv =====
// prefix decode and table lookup for one scan-code byte
`timescale 1ns / 1ps

module kscd_lookup (
	input  kscd_pkg::pstate_t   state,
	input  logic [7:0]          scan_byte,
	output kscd_pkg::pstate_t   state_next,
	output kscd_pkg::kscd_res_t res
);
	import kscd_pkg::*;

	logic [6:0] low;
	entry_t     entry;

	assign low = scan_byte[6:0];

	// prefix state machine and table select
	always_comb begin
		state_next = state;
		entry      = '0;
		unique case (state)
			PS_NORMAL: begin
				if (scan_byte == PREFIX_E0) begin
					state_next = PS_AFTER_E0;
				end else if (scan_byte == PREFIX_E1) begin
					state_next = PS_E1_FIRST;
				end else begin
					entry = base_entry(low);
				end
			end
			PS_AFTER_E0: begin
				entry      = ext_entry(low);
				state_next = PS_NORMAL;
			end
			PS_E1_FIRST: begin
				state_next = PS_E1_SECOND;
			end
			PS_E1_SECOND: begin
				entry      = sp(K_PAUSE);
				state_next = PS_NORMAL;
			end
			default: begin
				state_next = PS_NORMAL;
			end
		endcase
	end

	// an empty entry gives no item
	assign res.hit        = (entry != '0);
	assign res.key_code   = entry[6:0];
	assign res.is_special = entry[7];
	assign res.released   = scan_byte[7];

endmodule

// ===== hw/rtl/keyboard_scancode_decoder_unit.sv =====
// Scan-code set 1 decoder: takes one keyboard byte per cycle when ready, gives a translated key item.
// Each accepted scan_byte passes through the E0/E1 prefix state machine and a constant table
// lookup in the same cycle, and the translation lands in the result register; one byte is
// accepted every cycle while scan_ready is high. Prefix bytes, empty table entries and the
// first byte after E1 give no item. The result register sits between the two
// channels, so a new byte is still taken while a finished item waits, as long as key_ready
// frees the register in that same cycle. key_code is ASCII, or a special key index
// (0 left ctrl ... 51 pause, 52 sysrq) when is_special is set; released is bit 7 of the byte.
`timescale 1ns / 1ps

module keyboard_scancode_decoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       scan_valid,
	output logic       scan_ready,
	input  logic [7:0] scan_byte,
	output logic       key_valid,
	input  logic       key_ready,
	output logic [6:0] key_code,
	output logic       is_special,
	output logic       released
);
	import kscd_pkg::*;

	pstate_t   state_q;
	pstate_t   state_next;
	kscd_res_t res;
	logic      accept;
	logic      key_valid_q;
	logic [6:0] key_code_q;
	logic      is_special_q;
	logic      released_q;

	// handshake: take a byte whenever the result register is free or being emptied
	assign scan_ready = !key_valid_q || key_ready;
	assign accept     = scan_valid && scan_ready;

	kscd_lookup u_lookup (
		.state      (state_q),
		.scan_byte  (scan_byte),
		.state_next (state_next),
		.res        (res)
	);

	// prefix state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= PS_NORMAL;
			key_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q     <= state_next;
				key_valid_q <= res.hit;
			end else if (key_ready) begin
				key_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept && res.hit) begin
			key_code_q   <= res.key_code;
			is_special_q <= res.is_special;
			released_q   <= res.released;
		end
	end

	assign key_valid  = key_valid_q;
	assign key_code   = key_code_q;
	assign is_special = is_special_q;
	assign released   = released_q;

endmodule
